[rtl/core/pfi_pkg.sv]
// Package of shared types, constants and helpers for the palette fade interpolator.
`default_nettype none

package pfi_pkg;

	// Default palette depth and the fixed widths of the color path.
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int CH_W                = 8;
	localparam int NUM_CH              = 3;
	localparam int FADE_W              = 6;
	localparam int IDX_W               = 8;

	// The divider produces one quotient bit per cycle over a 16-bit dividend.
	localparam int DIV_BITS = 16;
	localparam int DCNT_W   = $clog2(DIV_BITS);

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FADE_MODE   = 3'd0,
		CFG_RANGE_FIRST = 3'd1,
		CFG_RANGE_LAST  = 3'd2,
		CFG_STEP_COUNT  = 3'd3,
		CFG_FADE_RED    = 3'd4,
		CFG_FADE_GREEN  = 3'd5,
		CFG_FADE_BLUE   = 3'd6
	} cfg_idx_t;

	// Input item kinds.
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	// Fade mode codes.
	localparam logic MODE_FIXED    = 1'b0;
	localparam logic MODE_PER_ITEM = 1'b1;

	// One color: lane 2 is red, lane 1 green, lane 0 blue.
	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	// Classified compute item handed from front to back. When blend is low,
	// src already holds the final color.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             blend;
		rgb_t             src;
		rgb_t             tgt;
		logic [CH_W-1:0]  step;
		logic [CH_W-1:0]  count;
	} item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Scale a six-bit color by 255/63 with truncation: 4c + floor(c/21).
	function automatic logic [CH_W-1:0] scale6(input logic [FADE_W-1:0] c);
		logic [1:0] extra;
		extra = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
		return {c, 2'b00} + {6'd0, extra};
	endfunction

endpackage

`default_nettype wire

[rtl/core/pfi_front.sv]
// Front end: configuration registers, palette store, and item classification.
`default_nettype none

module pfi_front
	import pfi_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 kind,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic [CH_W-1:0]      frame_step,
	input  wire logic [CH_W-1:0]      color_red,
	input  wire logic [CH_W-1:0]      color_green,
	input  wire logic [CH_W-1:0]      color_blue,
	// Configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CH_W-1:0]      cfg_data,
	// Queue push side
	output logic                      push,
	output item_t                     push_item,
	input  wire q_status_t            q_status
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// Configuration registers.
	logic            fade_mode_q;
	logic [CH_W-1:0] range_first_q;
	logic [CH_W-1:0] range_last_q;
	logic [CH_W-1:0] step_count_q;
	logic [FADE_W-1:0] fade_red_q;
	logic [FADE_W-1:0] fade_green_q;
	logic [FADE_W-1:0] fade_blue_q;

	// Palette store and its registered read data.
	rgb_t mem [PALETTE_ENTRIES];
	rgb_t rd_q;

	// Stage holding a compute item while its palette read completes.
	logic            valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic            beyond_s1;
	logic            in_range_s1;
	logic            sat_s1;
	rgb_t            tgt_s1;
	logic [CH_W-1:0] step_s1;
	logic [CH_W-1:0] count_s1;

	logic    in_acc;
	logic    in_store;
	logic [AW-1:0] addr;
	rgb_t    in_color;
	rgb_t    tgt_sel;
	rgb_t    src_s1;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_mode_q   <= MODE_FIXED;
			range_first_q <= 8'd0;
			range_last_q  <= 8'd255;
			step_count_q  <= 8'd32;
			fade_red_q    <= '0;
			fade_green_q  <= '0;
			fade_blue_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FADE_MODE:   fade_mode_q   <= cfg_data[0];
				CFG_RANGE_FIRST: range_first_q <= cfg_data;
				CFG_RANGE_LAST:  range_last_q  <= cfg_data;
				CFG_STEP_COUNT:  step_count_q  <= cfg_data;
				CFG_FADE_RED:    fade_red_q    <= cfg_data[FADE_W-1:0];
				CFG_FADE_GREEN:  fade_green_q  <= cfg_data[FADE_W-1:0];
				CFG_FADE_BLUE:   fade_blue_q   <= cfg_data[FADE_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept while the stage is free or drains into the queue this cycle.
	assign in_stall = valid_s1 && q_status.full;
	assign in_acc   = in_valid && !in_stall;
	assign in_store = {1'b0, entry_index} < 9'(PALETTE_ENTRIES);
	assign addr     = entry_index[AW-1:0];
	assign in_color = {color_red, color_green, color_blue};

	// Target color chosen by fade mode.
	always_comb begin
		if (fade_mode_q == MODE_PER_ITEM) begin
			tgt_sel = in_color;
		end else begin
			tgt_sel = {scale6(fade_red_q), scale6(fade_green_q), scale6(fade_blue_q)};
		end
	end

	// Palette write on load, registered read on compute.
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_LOAD && in_store) begin
			mem[addr] <= in_color;
		end
		if (in_acc && kind == KIND_COMPUTE) begin
			rd_q <= mem[addr];
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && kind == KIND_COMPUTE) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classification of a compute item.
	always_ff @(posedge clk) begin
		if (in_acc && kind == KIND_COMPUTE) begin
			idx_s1      <= entry_index;
			beyond_s1   <= !in_store;
			in_range_s1 <= (entry_index >= range_first_q) && (entry_index <= range_last_q);
			sat_s1      <= frame_step >= step_count_q;
			tgt_s1      <= tgt_sel;
			step_s1     <= frame_step;
			count_s1    <= step_count_q;
		end
	end

	// Build the queue entry; pass-through and saturated items are final here.
	assign push   = valid_s1 && !q_status.full;
	assign src_s1 = beyond_s1 ? '0 : rd_q;

	always_comb begin
		push_item.idx   = idx_s1;
		push_item.tgt   = tgt_s1;
		push_item.step  = step_s1;
		push_item.count = count_s1;
		if (!in_range_s1) begin
			push_item.blend = 1'b0;
			push_item.src   = src_s1;
		end else if (sat_s1) begin
			push_item.blend = 1'b0;
			push_item.src   = tgt_s1;
		end else begin
			push_item.blend = 1'b1;
			push_item.src   = src_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/core/pfi_queue.sv]
// Short queue of classified items between the front and the back.
`default_nettype none

module pfi_queue
	import pfi_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output q_status_t  status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;
	assign head         = slots_q[rd_ptr_q];

	// Storage for queued items.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("queue push while full");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("queue pop while empty");

	// Fill count tracks the pointers.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(QUEUE_DEPTH)) &&
		((count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) == (wr_ptr_q == rd_ptr_q)))
		else $error("queue fill count disagrees with pointers");

endmodule

`default_nettype wire

[rtl/core/pfi_back.sv]
// Back end: per-channel multiply, bit-serial signed divide, and output register.
`default_nettype none

module pfi_back
	import pfi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Queue pop side
	output logic                   pop,
	input  wire item_t             head,
	input  wire q_status_t         q_status,
	// Output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [IDX_W-1:0]       out_index,
	output logic [CH_W-1:0]        out_red,
	output logic [CH_W-1:0]        out_green,
	output logic [CH_W-1:0]        out_blue
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t              state_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]    idx_q;
	rgb_t                src_q;
	rgb_t                tgt_q;
	logic [CH_W-1:0]     step_q;
	logic [CH_W-1:0]     count_q;
	logic [NUM_CH-1:0]   neg_q;
	logic [NUM_CH-1:0][DIV_BITS-1:0] dvd_q;
	logic [NUM_CH-1:0][CH_W-1:0]     rem_q;

	logic             out_valid_q;
	logic             out_free;
	logic             out_load;
	logic [IDX_W-1:0] out_index_q;
	rgb_t             out_color_q;

	logic [NUM_CH-1:0]               neg_d;
	logic [NUM_CH-1:0][DIV_BITS-1:0] mag_d;
	logic [NUM_CH-1:0][DIV_BITS-1:0] dvd_d;
	logic [NUM_CH-1:0][CH_W-1:0]     rem_d;
	rgb_t                            res_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !q_status.empty && (head.blend || out_free);
	assign out_load  = (pop && !head.blend) || ((state_q == ST_FIN) && out_free);
	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_red   = out_color_q[2];
	assign out_green = out_color_q[1];
	assign out_blue  = out_color_q[0];

	// Per-lane signed product of difference and step, split into sign and magnitude.
	always_comb begin
		for (int l = 0; l < NUM_CH; l++) begin
			logic signed [CH_W:0]     delta;
			logic signed [2*CH_W+1:0] prod;
			delta    = $signed({1'b0, tgt_q[l]}) - $signed({1'b0, src_q[l]});
			prod     = delta * $signed({1'b0, step_q});
			neg_d[l] = prod < 0;
			mag_d[l] = neg_d[l] ? DIV_BITS'(-prod) : DIV_BITS'(prod);
		end
	end

	// One restoring divide step per lane.
	always_comb begin
		for (int l = 0; l < NUM_CH; l++) begin
			logic [CH_W:0] trial;
			trial = {rem_q[l], dvd_q[l][DIV_BITS-1]};
			if (trial >= {1'b0, count_q}) begin
				rem_d[l] = CH_W'(trial - {1'b0, count_q});
				dvd_d[l] = {dvd_q[l][DIV_BITS-2:0], 1'b1};
			end else begin
				rem_d[l] = trial[CH_W-1:0];
				dvd_d[l] = {dvd_q[l][DIV_BITS-2:0], 1'b0};
			end
		end
	end

	// Apply the quotient sign and add the source; wraps to eight bits.
	always_comb begin
		for (int l = 0; l < NUM_CH; l++) begin
			logic [CH_W-1:0] q8;
			q8       = dvd_q[l][CH_W-1:0];
			res_d[l] = src_q[l] + (neg_q[l] ? (~q8 + 1'b1) : q8);
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_color_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.blend) begin
							state_q <= ST_MUL;
						end else begin
							out_index_q <= head.idx;
							out_color_q <= head.src;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= DCNT_W'(DIV_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_index_q <= idx_q;
						out_color_q <= res_d;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					idx_q   <= head.idx;
					src_q   <= head.src;
					tgt_q   <= head.tgt;
					step_q  <= head.step;
					count_q <= head.count;
				end
			end
			ST_MUL: begin
				neg_q <= neg_d;
				dvd_q <= mag_d;
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= dvd_d;
				rem_q <= rem_d;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/palette_fade_interpolator_top.sv]
// Top level of the palette fade interpolator: front, queue and back.
//
//   Channel   Direction  Handshake            Beat payload
//   in        input      in_valid / in_stall  kind, entry_index, frame_step, color_*
//   out       output     out_valid / out_stall out_index, out_red, out_green, out_blue
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load beat writes the palette entry when it is taken.
// A compute beat is registered in the front stage with its palette read, then queued
// when the queue has room; a pass-through or saturated entry goes on to the output
// register, a blended one after the bit-serial divide of all three lanes in lockstep.
// Reset clears control state and the output register; palette entries hold nothing until loaded.
// The queue lets the front keep taking beats while the back works or is stalled.
`default_nettype none

module palette_fade_interpolator_top
	import pfi_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 kind,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic [CH_W-1:0]      frame_step,
	input  wire logic [CH_W-1:0]      color_red,
	input  wire logic [CH_W-1:0]      color_green,
	input  wire logic [CH_W-1:0]      color_blue,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [IDX_W-1:0]          out_index,
	output logic [CH_W-1:0]           out_red,
	output logic [CH_W-1:0]           out_green,
	output logic [CH_W-1:0]           out_blue,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CH_W-1:0]      cfg_data
);

	logic      push;
	item_t     push_item;
	logic      pop;
	item_t     head;
	q_status_t q_status;

	// Front: configuration, palette store and classification.
	pfi_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.entry_index (entry_index),
		.frame_step  (frame_step),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.push_item   (push_item),
		.q_status    (q_status)
	);

	// Queue between the two halves.
	pfi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Back: interpolation and output register.
	pfi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_index (out_index),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

endmodule

`default_nettype wire

[tb/pfi_fade_checker.sv]
`timescale 1ns / 1ps
// Checker for the palette fade interpolator: tracks the channels, predicts colors and compares.
module pfi_fade_checker
	import pfi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic                 kind,
	input  wire logic [IDX_W-1:0]     entry_index,
	input  wire logic [CH_W-1:0]      frame_step,
	input  wire logic [CH_W-1:0]      color_red,
	input  wire logic [CH_W-1:0]      color_green,
	input  wire logic [CH_W-1:0]      color_blue,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [IDX_W-1:0]     out_index,
	input  wire logic [CH_W-1:0]      out_red,
	input  wire logic [CH_W-1:0]      out_green,
	input  wire logic [CH_W-1:0]      out_blue,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CH_W-1:0]      cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} color_beat_t;

	// Colors still owed by the block, oldest first.
	color_beat_t expected_colors[$];

	// Shadow of the source palette and of the fade registers.
	logic [NUM_CH*CH_W-1:0] palette_copy [PALETTE_ENTRIES_DEF];
	logic                   mode_now;
	logic [IDX_W-1:0]       first_now;
	logic [IDX_W-1:0]       last_now;
	logic [CH_W-1:0]        count_now;
	logic [FADE_W-1:0]      fade_r_now;
	logic [FADE_W-1:0]      fade_g_now;
	logic [FADE_W-1:0]      fade_b_now;

	int n_fail = 0;
	int n_checked = 0;

	// Prints one failure line and counts it.
	task automatic report_failure(string msg);
		$display("%0t ns: %s", $time, msg);
		n_fail++;
	endtask

	// Widens a six-bit fade level to eight bits by 255/63 with truncation.
	function automatic logic [CH_W-1:0] widen_fade(logic [FADE_W-1:0] level);
		return CH_W'((int'(level) * 255) / 63);
	endfunction

	// Moves one channel from src toward dst by step/count, truncating toward zero.
	function automatic logic [CH_W-1:0] fade_lane(logic [CH_W-1:0] src, logic [CH_W-1:0] dst,
			logic [CH_W-1:0] step, logic [CH_W-1:0] count);
		int delta;
		int part;
		if (step >= count) return dst;
		delta = int'(dst) - int'(src);
		part = (delta * int'(step)) / int'(count);
		return CH_W'(int'(src) + part);
	endfunction

	// Works out the color that one compute beat must produce.
	function automatic color_beat_t predict_color(logic [IDX_W-1:0] idx, logic [CH_W-1:0] step,
			logic [CH_W-1:0] tr, logic [CH_W-1:0] tg, logic [CH_W-1:0] tb);
		color_beat_t c;
		logic [NUM_CH*CH_W-1:0] src;
		src = palette_copy[idx];
		c.idx = idx;
		c.red = src[23:16];
		c.green = src[15:8];
		c.blue = src[7:0];
		if (idx >= first_now && idx <= last_now) begin
			if (mode_now == MODE_FIXED) begin
				tr = widen_fade(fade_r_now);
				tg = widen_fade(fade_g_now);
				tb = widen_fade(fade_b_now);
			end
			c.red = fade_lane(c.red, tr, step, count_now);
			c.green = fade_lane(c.green, tg, step, count_now);
			c.blue = fade_lane(c.blue, tb, step, count_now);
		end
		return c;
	endfunction

	// Compares a received color with the oldest expected one, field by field.
	task automatic compare_color(color_beat_t got, color_beat_t want);
		if (got.idx !== want.idx)
			report_failure($sformatf("out_index mismatch: got %0d, expected %0d",
				got.idx, want.idx));
		if (got.red !== want.red)
			report_failure($sformatf("out_red mismatch at index %0d: got %0d, expected %0d",
				want.idx, got.red, want.red));
		if (got.green !== want.green)
			report_failure($sformatf("out_green mismatch at index %0d: got %0d, expected %0d",
				want.idx, got.green, want.green));
		if (got.blue !== want.blue)
			report_failure($sformatf("out_blue mismatch at index %0d: got %0d, expected %0d",
				want.idx, got.blue, want.blue));
		n_checked++;
	endtask

	// Follows register writes, loads, computes and results beat by beat.
	always @(posedge clk or negedge arst_n) begin
		color_beat_t seen;
		if (!arst_n) begin
			mode_now = MODE_FIXED;
			first_now = 8'd0;
			last_now = 8'd255;
			count_now = 8'd32;
			fade_r_now = '0;
			fade_g_now = '0;
			fade_b_now = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FADE_MODE:   mode_now = cfg_data[0];
					CFG_RANGE_FIRST: first_now = cfg_data;
					CFG_RANGE_LAST:  last_now = cfg_data;
					CFG_STEP_COUNT:  count_now = cfg_data;
					CFG_FADE_RED:    fade_r_now = cfg_data[FADE_W-1:0];
					CFG_FADE_GREEN:  fade_g_now = cfg_data[FADE_W-1:0];
					CFG_FADE_BLUE:   fade_b_now = cfg_data[FADE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = {out_index, out_red, out_green, out_blue};
				if (expected_colors.size() == 0)
					report_failure($sformatf("unexpected result beat for index %0d", out_index));
				else
					compare_color(seen, expected_colors.pop_front());
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_LOAD)
					palette_copy[entry_index] = {color_red, color_green, color_blue};
				else
					expected_colors.push_back(predict_color(entry_index, frame_step,
						color_red, color_green, color_blue));
			end
		end
		fail_count <= n_fail;
		pending <= expected_colors.size();
		checked <= n_checked;
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the palette fade interpolator: clock, reset, stimulus and verdict.
module testbench;
	import pfi_pkg::*;

	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int SETTLE_CYCLES   = 32;
	localparam int END_CYCLES      = 40;

	// Idling patterns for the two sides.
	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	typedef struct {
		logic              mode;
		logic [IDX_W-1:0]  first;
		logic [IDX_W-1:0]  last;
		logic [CH_W-1:0]   count;
		logic [FADE_W-1:0] fr;
		logic [FADE_W-1:0] fg;
		logic [FADE_W-1:0] fb;
	} fade_setting_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             kind = KIND_LOAD;
	logic [IDX_W-1:0] entry_index = '0;
	logic [CH_W-1:0]  frame_step = '0;
	logic [CH_W-1:0]  color_red = '0;
	logic [CH_W-1:0]  color_green = '0;
	logic [CH_W-1:0]  color_blue = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [IDX_W-1:0] out_index;
	logic [CH_W-1:0]  out_red;
	logic [CH_W-1:0]  out_green;
	logic [CH_W-1:0]  out_blue;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_idx_t         cfg_index = CFG_FADE_MODE;
	logic [CH_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	int checked;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int n_loads = 0;
	int n_computes = 0;
	int n_settings = 0;

	fade_setting_t    active;
	bit               loaded [PALETTE_ENTRIES_DEF];
	logic [IDX_W-1:0] loaded_list[$];

	palette_fade_interpolator_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.entry_index (entry_index),
		.frame_step  (frame_step),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_index   (out_index),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	pfi_fade_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.entry_index (entry_index),
		.frame_step  (frame_step),
		.color_red   (color_red),
		.color_green (color_green),
		.color_blue  (color_blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_index   (out_index),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Random stall on the result channel.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic fade_setting_t make_setting(logic mode, logic [IDX_W-1:0] first,
			logic [IDX_W-1:0] last, logic [CH_W-1:0] count, logic [FADE_W-1:0] fr,
			logic [FADE_W-1:0] fg, logic [FADE_W-1:0] fb);
		fade_setting_t s;
		s.mode = mode;
		s.first = first;
		s.last = last;
		s.count = count;
		s.fr = fr;
		s.fg = fg;
		s.fb = fb;
		return s;
	endfunction

	// Register setting for each random phase; the first ones hit the extremes.
	function automatic fade_setting_t phase_setting(int phase);
		case (phase)
			0: return make_setting(MODE_PER_ITEM, 8'd0, 8'd255, 8'd255, 6'd63, 6'd63, 6'd63);
			1: return make_setting(MODE_FIXED, 8'd0, 8'd255, 8'd1, 6'd63, 6'd0, 6'd21);
			5: return make_setting(1'($urandom_range(1)), 8'($urandom_range(255, 129)),
				8'($urandom_range(128)), 8'($urandom_range(255, 1)),
				6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
			6: return make_setting(MODE_PER_ITEM, 8'd0, 8'd255, 8'd0, 6'd0, 6'd0, 6'd0);
			default: return make_setting(1'($urandom_range(1)), 8'($urandom_range(100)),
				8'($urandom_range(255, 150)), 8'($urandom_range(255, 1)),
				6'($urandom_range(63)), 6'($urandom_range(63)), 6'($urandom_range(63)));
		endcase
	endfunction

	// Mostly random channel values, now and then a full-scale or zero one.
	function automatic logic [CH_W-1:0] rand_channel();
		if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// Frame steps cluster below, at and just under the step count.
	function automatic logic [CH_W-1:0] pick_step();
		int roll;
		roll = $urandom_range(99);
		if (active.count == 0 || roll >= 75) return 8'($urandom_range(255));
		if (roll < 60) return 8'($urandom_range(int'(active.count) - 1));
		if (roll < 68) return active.count;
		return active.count - 8'd1;
	endfunction

	task automatic set_idling(int pattern);
		send_idle_pct = (pattern == IDLE_SENDER) ? 71 : (pattern == IDLE_BOTH) ? 23 : 0;
		stall_pct <= (pattern == IDLE_RECEIVER) ? 71 : (pattern == IDLE_BOTH) ? 23 : 0;
	endtask

	// Drives one input beat, after any idle cycles, and waits until it is taken.
	task automatic push_item(logic k, logic [IDX_W-1:0] idx, logic [CH_W-1:0] step,
			logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		entry_index <= idx;
		frame_step <= step;
		color_red <= r;
		color_green <= g;
		color_blue <= b;
		do @(posedge clk); while (in_stall);
		if (k == KIND_LOAD) begin
			n_loads++;
			if (!loaded[idx]) begin
				loaded[idx] = 1'b1;
				loaded_list.push_back(idx);
			end
		end else begin
			n_computes++;
		end
	endtask

	// Stops sending and waits until every expected color has come back.
	task automatic drain_results(int guard);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (guard) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CH_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all seven registers once the block has gone quiet.
	task automatic apply_setting(fade_setting_t s);
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_FADE_MODE, {7'd0, s.mode});
		write_reg(CFG_RANGE_FIRST, s.first);
		write_reg(CFG_RANGE_LAST, s.last);
		write_reg(CFG_STEP_COUNT, s.count);
		write_reg(CFG_FADE_RED, {2'b00, s.fr});
		write_reg(CFG_FADE_GREEN, {2'b00, s.fg});
		write_reg(CFG_FADE_BLUE, {2'b00, s.fb});
		cfg_valid <= 1'b0;
		active = s;
		n_settings++;
	endtask

	// One random beat: a load anywhere, or a compute of an entry already loaded.
	task automatic random_item();
		logic [IDX_W-1:0] idx;
		if ($urandom_range(99) < 30 || loaded_list.size() == 0) begin
			idx = 8'($urandom_range(255));
			push_item(KIND_LOAD, idx, 8'($urandom_range(255)), rand_channel(), rand_channel(),
				rand_channel());
		end else begin
			idx = loaded_list[$urandom_range(loaded_list.size() - 1)];
			push_item(KIND_COMPUTE, idx, pick_step(), rand_channel(), rand_channel(),
				rand_channel());
		end
	endtask

	// Main sequence: reset, directed beats, random phases, then the verdict.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		active = make_setting(MODE_FIXED, 8'd0, 8'd255, 8'd32, 6'd0, 6'd0, 6'd0);
		set_idling(IDLE_NONE);

		// Directed loads of extreme and mixed colors.
		push_item(KIND_LOAD, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
		push_item(KIND_LOAD, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00);
		push_item(KIND_LOAD, 8'd128, 8'd0, 8'h80, 8'h7f, 8'h01);
		push_item(KIND_LOAD, 8'd1, 8'd0, 8'h55, 8'haa, 8'h0f);
		push_item(KIND_LOAD, 8'd170, 8'd0, 8'h01, 8'hfe, 8'h80);

		// Reset setting: fade toward black over 32 steps; item colors are ignored.
		push_item(KIND_COMPUTE, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd0, 8'd1, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd0, 8'd31, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd0, 8'd32, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd128, 8'd16, 8'h00, 8'h00, 8'h00);
		push_item(KIND_COMPUTE, 8'd1, 8'd7, 8'h00, 8'h00, 8'h00);

		// Per-item targets over a range that leaves out both ends.
		apply_setting(make_setting(MODE_PER_ITEM, 8'd1, 8'd254, 8'd255, 6'd63, 6'd63, 6'd63));
		push_item(KIND_COMPUTE, 8'd0, 8'd100, 8'h00, 8'h00, 8'h00);
		push_item(KIND_COMPUTE, 8'd255, 8'd3, 8'hff, 8'hff, 8'hff);
		push_item(KIND_COMPUTE, 8'd128, 8'd254, 8'hff, 8'h00, 8'hff);
		push_item(KIND_COMPUTE, 8'd1, 8'd100, 8'h00, 8'hff, 8'h80);
		push_item(KIND_COMPUTE, 8'd170, 8'd255, 8'h12, 8'h34, 8'h56);

		// Empty range: first above last, so every entry passes through.
		apply_setting(make_setting(MODE_FIXED, 8'd200, 8'd10, 8'd5, 6'd63, 6'd0, 6'd42));
		push_item(KIND_COMPUTE, 8'd128, 8'd2, 8'h00, 8'h00, 8'h00);
		push_item(KIND_COMPUTE, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00);

		// A step count of zero makes every step land on the target.
		apply_setting(make_setting(MODE_FIXED, 8'd0, 8'd255, 8'd0, 6'd63, 6'd21, 6'd42));
		push_item(KIND_COMPUTE, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00);
		push_item(KIND_COMPUTE, 8'd255, 8'd200, 8'h00, 8'h00, 8'h00);

		// Random phases, each with its own setting and idling pattern.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_idling(phase % 4);
			apply_setting(phase_setting(phase));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 4 && n == ITEMS_PER_PHASE / 2) drain_results(0);
				random_item();
			end
		end

		drain_results(END_CYCLES);
		$display("Covered %0d loads and %0d computes, %0d settings, four idling patterns.",
			n_loads, n_computes, n_settings);
		$display("%0d result colors were compared field by field.", checked);
		if (fail_count == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule
